// ===== src/tae_pkg.sv =====
`default_nettype none

package tae_pkg;

  // Table depth default
  localparam int unsigned SLOTS_DEF = 16;

  // Microsecond limits
  localparam logic [20:0] MICRO_MAX  = 21'd999999;
  localparam logic [20:0] MICRO_WRAP = 21'd1000000;

  // Register reset values
  localparam logic [19:0] TICK_MICRO_RST = 20'd20000;
  localparam logic [7:0]  TICK_SECS_RST  = 8'd0;

  // Configuration register indexes
  localparam logic REG_TICK_MICRO = 1'b0;
  localparam logic REG_TICK_SECS  = 1'b1;

  // Request kinds
  localparam logic KIND_DELAY = 1'b0;
  localparam logic KIND_ALARM = 1'b1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_EXPIRED   = 2'd0,
    ST_ADDED     = 2'd1,
    ST_FULL      = 2'd2,
    ST_TICK_DONE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DELAYS,
    FSM_ALARMS
  } fsm_e;

  // Input request
  typedef struct packed {
    op_e         op;
    logic        kind;
    logic [31:0] deadline_secs;
    logic [19:0] deadline_micro;
    logic [7:0]  tag;
  } tae_in_t;

  // Result record
  typedef struct packed {
    status_e     status;
    logic [7:0]  out_tag;
    logic        out_kind;
    logic        last;
  } tae_out_t;

  // Seconds plus microseconds
  typedef struct packed {
    logic [31:0] secs;
    logic [19:0] micro;
  } clk_t;

  // Stored request of one cell
  typedef struct packed {
    logic        kind;
    logic [31:0] secs;
    logic [19:0] micro;
    logic [7:0]  tag;
  } slot_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic add;
    logic remove;
    logic pass_kind;
    clk_t pass_clk;
  } cell_ctrl_t;

  // Find-first chain between neighbor cells
  typedef struct packed {
    logic       hit;
    logic [7:0] tag;
  } chain_t;

  // Advance a clock by one tick period, carrying at one million
  function automatic clk_t clock_add(clk_t c, logic [19:0] tick_micro,
                                     logic [7:0] tick_secs);
    logic [20:0] tm;
    logic [20:0] m;
    logic [31:0] s;
    clk_t        r;
    tm = ({1'b0, tick_micro} > MICRO_MAX) ? MICRO_MAX : {1'b0, tick_micro};
    m  = {1'b0, c.micro} + tm;
    s  = c.secs + {24'd0, tick_secs};
    if (m > MICRO_MAX) begin
      s = s + 32'd1;
      m = m - MICRO_WRAP;
    end
    r.secs  = s;
    r.micro = m[19:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tae_cell.sv =====
`default_nettype none

module tae_cell
  import tae_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire slot_t      new_slot_i,
  input  wire logic       prev_valid_i,
  input  wire logic       next_valid_i,
  input  wire slot_t      next_slot_i,
  input  wire chain_t     chain_i,
  output chain_t          chain_o,
  output logic            valid_o,
  output slot_t           slot_o
);

  logic  valid_q, valid_d;
  slot_t slot_q, slot_d;
  logic  due;
  logic  hit;
  logic  load;
  logic  shift;

  // Deadline strictly earlier than the pass clock
  assign due = (slot_q.secs < ctrl_i.pass_clk.secs) ||
               ((slot_q.secs == ctrl_i.pass_clk.secs) &&
                (slot_q.micro < ctrl_i.pass_clk.micro));
  assign hit = valid_q && (slot_q.kind == ctrl_i.pass_kind) && due;

  // First-hit chain: earlier cells win, tag rides along
  assign chain_o.hit = chain_i.hit | hit;
  assign chain_o.tag = (!chain_i.hit && hit) ? slot_q.tag : chain_i.tag;

  // First free cell takes an add; cells at or past the removed one shift down
  assign load  = ctrl_i.add && !valid_q && prev_valid_i;
  assign shift = ctrl_i.remove && chain_o.hit;

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    if (shift) begin
      valid_d = next_valid_i;
      slot_d  = next_slot_i;
    end else if (load) begin
      valid_d = 1'b1;
      slot_d  = new_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule

`default_nettype wire

// ===== src/tick_alarm_expiry_table_unit.sv =====
`default_nettype none

// Timer table with wall and elapsed clocks. An add request is accepted when
// start is high and busy low, and its single result (added, or rejected
// when the table is full) appears on res_o with out_strobe_o in the next cycle;
// busy stays low, so adds can follow every cycle. A tick request advances
// both clocks at once, then scans the row of SLOTS cells: an expired record
// for each expired delay, a last delay step with no hit, an expired record for
// each expired alarm, and a final step that issues the tick-done record. Busy
// stays high through these steps, with at most one result per cycle.
// Each result is valid for exactly the one cycle out_strobe_o is high; the
// receiver cannot stall. Configuration writes are taken at any edge with
// cfg_we_i high and must only be made while the block is idle.
module tick_alarm_expiry_table_unit
  import tae_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire tae_in_t     req_i,
  output logic             out_strobe_o,
  output tae_out_t         res_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);

  fsm_e       fsm_q, fsm_d;
  logic [19:0] tick_micro_q;
  logic [7:0]  tick_secs_q;
  clk_t       wall_q, elapsed_q;
  logic       strobe_q, strobe_d;
  tae_out_t   res_q, res_d;
  cell_ctrl_t ctrl;
  slot_t      new_slot;
  logic       accept;
  logic       full;
  logic       any_hit;

  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS:0]   prev_valid;
  logic [SLOTS:0]   next_valid;
  slot_t            slot_arr [SLOTS+1];
  chain_t           chain    [SLOTS+1];

  assign accept = start && !busy;
  assign full   = valid_vec[SLOTS-1];
  assign any_hit = chain[SLOTS].hit;

  assign new_slot.kind  = req_i.kind;
  assign new_slot.secs  = req_i.deadline_secs;
  assign new_slot.micro = req_i.deadline_micro;
  assign new_slot.tag   = req_i.tag;

  // Neighbor links at both ends of the row
  assign prev_valid[0]    = 1'b1;
  assign next_valid[SLOTS] = 1'b0;
  assign slot_arr[SLOTS]  = '0;
  assign chain[0]         = '0;

  // Row of cells, one request each, in insertion order
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign prev_valid[i+1] = valid_vec[i];
    assign next_valid[i]   = valid_vec[i];
    tae_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_slot_i   (new_slot),
      .prev_valid_i (prev_valid[i]),
      .next_valid_i (next_valid[i+1]),
      .next_slot_i  (slot_arr[i+1]),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .valid_o      (valid_vec[i]),
      .slot_o       (slot_arr[i])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_micro_q <= TICK_MICRO_RST;
      tick_secs_q  <= TICK_SECS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TICK_MICRO: tick_micro_q <= cfg_data_i;
        REG_TICK_SECS:  tick_secs_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Clocks advance when a tick is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q    <= '0;
      elapsed_q <= '0;
    end else if (accept && req_i.op == OP_TICK) begin
      wall_q    <= clock_add(wall_q, tick_micro_q, tick_secs_q);
      elapsed_q <= clock_add(elapsed_q, tick_micro_q, tick_secs_q);
    end
  end

  // Next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FSM_IDLE:   if (accept && req_i.op == OP_TICK) fsm_d = FSM_DELAYS;
      FSM_DELAYS: if (!any_hit) fsm_d = FSM_ALARMS;
      FSM_ALARMS: if (!any_hit) fsm_d = FSM_IDLE;
      default:    fsm_d = FSM_IDLE;
    endcase
  end

  // Cell control and result
  always_comb begin
    ctrl.add       = 1'b0;
    ctrl.remove    = 1'b0;
    ctrl.pass_kind = KIND_DELAY;
    ctrl.pass_clk  = elapsed_q;
    strobe_d       = 1'b0;
    res_d          = '0;
    busy           = 1'b1;
    unique case (fsm_q)
      FSM_IDLE: begin
        busy = 1'b0;
        if (accept && req_i.op == OP_ADD) begin
          strobe_d   = 1'b1;
          res_d.last = 1'b1;
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            ctrl.add       = 1'b1;
            res_d.status   = ST_ADDED;
            res_d.out_tag  = req_i.tag;
            res_d.out_kind = req_i.kind;
          end
        end
      end
      FSM_DELAYS: begin
        if (any_hit) begin
          ctrl.remove    = 1'b1;
          strobe_d       = 1'b1;
          res_d.status   = ST_EXPIRED;
          res_d.out_tag  = chain[SLOTS].tag;
          res_d.out_kind = KIND_DELAY;
        end
      end
      FSM_ALARMS: begin
        ctrl.pass_kind = KIND_ALARM;
        ctrl.pass_clk  = wall_q;
        strobe_d       = 1'b1;
        if (any_hit) begin
          ctrl.remove    = 1'b1;
          res_d.status   = ST_EXPIRED;
          res_d.out_tag  = chain[SLOTS].tag;
          res_d.out_kind = KIND_ALARM;
        end else begin
          res_d.status = ST_TICK_DONE;
          res_d.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= FSM_IDLE;
      strobe_q <= 1'b0;
    end else begin
      fsm_q    <= fsm_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_strobe_o = strobe_q;
  assign res_o        = res_q;

  // Valid cells always form a run from cell zero
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("table holds a gap");

  // A removal takes exactly one entry out
  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> $countones(valid_vec) == $countones($past(valid_vec)) - 1)
    else $error("removal did not drop one entry");

  // An add with room is answered next cycle and stored
  a_add_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == OP_ADD && !full) |=>
      (out_strobe_o && res_o.status == ST_ADDED &&
       $countones(valid_vec) == $countones($past(valid_vec)) + 1))
    else $error("add not stored");

  // The alarm pass ends with tick done and an idle block
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == FSM_ALARMS && !any_hit) |=>
      (out_strobe_o && res_o.status == ST_TICK_DONE && res_o.last && !busy))
    else $error("tick did not close");

  // Expiry records never close a request
  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && res_o.status == ST_EXPIRED) |-> !res_o.last)
    else $error("expiry marked last");

endmodule

`default_nettype wire
